>>> hw/rtl/wcrs_pkg.sv
package wcrs_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 8;

  localparam int unsigned ADDR_W  = 13;
  localparam int unsigned MASK_W  = 3;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;

  localparam logic [MASK_W-1:0] MASK_RESET = 3'd7;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_MASK     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALT_OVERFLOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALT_UNDERFLOW = 2'd2;

  localparam logic signed [LEVEL_W-1:0] LEVEL_MAX = 8'sd127;
  localparam logic signed [LEVEL_W-1:0] LEVEL_MIN = -8'sd128;

  typedef struct packed {
    logic [MASK_W-1:0] slot_mask;
    logic              halt_on_overflow;
    logic              halt_on_underflow;
  } wcrs_cfg_t;

  // Folds a masked slot number into the stack depth. The value is below 8,
  // so at most seven subtractions are ever needed.
  function automatic logic [MASK_W-1:0] slot_reduce(input logic [MASK_W-1:0] v,
                                                    input int unsigned depth);
    logic [MASK_W:0] acc;
    logic [MASK_W:0] d;
    acc = {1'b0, v};
    d   = (MASK_W+1)'(depth);
    for (int i = 0; i < 7; i++) begin
      if (acc >= d) begin
        acc = acc - d;
      end
    end
    return acc[MASK_W-1:0];
  endfunction

endpackage

>>> hw/rtl/wcrs_in_if.sv
interface wcrs_in_if import wcrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ADDR_W-1:0] push_address;

  modport source (output valid, output cmd, output push_address, input ready);
  modport sink   (input valid, input cmd, input push_address, output ready);
endinterface

>>> hw/rtl/wcrs_out_if.sv
interface wcrs_out_if import wcrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] pop_data;
  logic              overflow;
  logic              underflow;
  logic              halt_request;

  modport source (output valid, output pop_data, output overflow, output underflow,
                  output halt_request, input ready);
  modport sink   (input valid, input pop_data, input overflow, input underflow,
                  input halt_request, output ready);
endinterface

>>> hw/rtl/wcrs_slot_ram.sv
module wcrs_slot_ram import wcrs_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  logic [ADDR_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [ADDR_W-1:0] rd_data
);

  logic [ADDR_W-1:0]      mem [STACK_DEPTH];
  logic [STACK_DEPTH-1:0] valid_r;
  logic [ADDR_W-1:0]      rd_raw_r;
  logic                   rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_r <= mem[rd_idx];
    end
  end

  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_idx];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_raw_r : '0;

endmodule

>>> hw/rtl/wcrs_ctrl.sv
module wcrs_ctrl import wcrs_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wcrs_cfg_t         cfg,
  wcrs_in_if.sink           in_ch,
  wcrs_out_if.source        out_ch,
  output logic              ram_wr_en,
  output logic              ram_rd_en,
  output logic [IDX_W-1:0]  ram_idx,
  output logic [ADDR_W-1:0] ram_wr_data,
  input  logic [ADDR_W-1:0] ram_rd_data
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                      state_r, state_nxt;
  logic signed [LEVEL_W-1:0] level_r, level_nxt;
  logic signed [LEVEL_W-1:0] level_inc, level_dec, level_sel;
  logic                      out_valid_r;
  logic [ADDR_W-1:0]         pop_data_r;
  logic                      overflow_r, underflow_r, halt_r;
  logic                      unf_pend_r;
  logic                      accept, is_push, ovf, unf;
  logic [MASK_W-1:0]         slot;
  logic [IDX_W+MASK_W-1:0]   slot_ext;

  assign in_ch.ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_push     = (in_ch.cmd == CMD_PUSH);

  assign level_inc = (level_r != LEVEL_MAX) ? level_r + 8'sd1 : level_r;
  assign level_dec = (level_r != LEVEL_MIN) ? level_r - 8'sd1 : level_r;
  // A push uses the slot at the current level, a pop the one at the new level.
  assign level_sel = is_push ? level_r : level_dec;

  assign slot     = slot_reduce(level_sel[MASK_W-1:0] & cfg.slot_mask, STACK_DEPTH);
  assign slot_ext = {{IDX_W{1'b0}}, slot};

  assign ovf = (level_r >= $signed({{(LEVEL_W-MASK_W){1'b0}}, cfg.slot_mask}));
  assign unf = level_dec[LEVEL_W-1];

  assign ram_wr_en   = accept && is_push;
  assign ram_rd_en   = accept && !is_push;
  assign ram_idx     = slot_ext[IDX_W-1:0];
  assign ram_wr_data = in_ch.push_address;

  always_comb begin
    state_nxt = state_r;
    level_nxt = level_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          level_nxt = is_push ? level_inc : level_dec;
          state_nxt = is_push ? ST_IDLE : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      level_r <= level_nxt;
      if ((accept && is_push) || (state_r == ST_READ)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_push) begin
      unf_pend_r <= unf;
    end
    if (accept && is_push) begin
      pop_data_r  <= '0;
      overflow_r  <= ovf;
      underflow_r <= 1'b0;
      halt_r      <= ovf && cfg.halt_on_overflow;
    end else if (state_r == ST_READ) begin
      // The slot read issued at the pop transfer is back in the cycle after it.
      pop_data_r  <= ram_rd_data;
      overflow_r  <= 1'b0;
      underflow_r <= unf_pend_r;
      halt_r      <= unf_pend_r && cfg.halt_on_underflow;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.pop_data     = pop_data_r;
  assign out_ch.overflow     = overflow_r;
  assign out_ch.underflow    = underflow_r;
  assign out_ch.halt_request = halt_r;

endmodule

>>> hw/rtl/wrapping_call_return_stack.sv
// Push: the result is registered at the input transfer and offered the next cycle.
// Pop: one slot memory read; the data passes the memory and output registers first.
// Throughput: one push per cycle if the sink keeps up; a pop holds input in ST_READ.
// A waiting result does not block a new transfer once the sink takes it.
// Synchronous active-low reset clears the level, the halt enables and the per-slot
// valid bits and sets slot mask to 7; the stack reads all zero with no clearing pass.
module wrapping_call_return_stack import wcrs_pkg::*; #(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  wcrs_in_if.sink               in_ch,
  wcrs_out_if.source            out_ch
);

  wcrs_cfg_t         cfg_r;
  logic              ram_wr_en, ram_rd_en;
  logic [IDX_W-1:0]  ram_idx;
  logic [ADDR_W-1:0] ram_wr_data, ram_rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slot_mask         <= MASK_RESET;
      cfg_r.halt_on_overflow  <= 1'b0;
      cfg_r.halt_on_underflow <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SLOT_MASK:      cfg_r.slot_mask         <= cfg_wdata[MASK_W-1:0];
        CFG_HALT_OVERFLOW:  cfg_r.halt_on_overflow  <= cfg_wdata[0];
        CFG_HALT_UNDERFLOW: cfg_r.halt_on_underflow <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  wcrs_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .ram_wr_en  (ram_wr_en),
    .ram_rd_en  (ram_rd_en),
    .ram_idx    (ram_idx),
    .ram_wr_data(ram_wr_data),
    .ram_rd_data(ram_rd_data)
  );

  wcrs_slot_ram #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_slot_ram (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (ram_wr_en),
    .wr_idx (ram_idx),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_idx (ram_idx),
    .rd_data(ram_rd_data)
  );

endmodule
